/* rtl/ucb1_node_rank_unit_defines.svh */
// ----------------------------------------------------------------------------
// UCB1 node rank unit: assertion macros
// Shared macros for the concurrent checks on the rank unit ports.
// ----------------------------------------------------------------------------
`ifndef UCB1_NODE_RANK_UNIT_DEFINES_SVH
`define UCB1_NODE_RANK_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define UCB1_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define UCB1_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/ucb1_pkg.sv */
// ----------------------------------------------------------------------------
// UCB1 package
// Fixed widths and constants of the UCB1 node rank unit.
// ----------------------------------------------------------------------------
package ucb1_pkg;

  localparam int RANK_W = 23;
  localparam logic [RANK_W-1:0] RANK_MAX = '1;
  localparam int FRAC_W = 16;
  localparam int MANT_W = 31;
  localparam int WEIGHT_W = 16;
  localparam int WEIGHT_SHIFT = 12;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd5793;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNVISITED = 2'd1;

endpackage

/* rtl/ucb1_if.sv */
// ----------------------------------------------------------------------------
// UCB1 channel interfaces
// Valid/ready channels for node counts in and rank results out.
// ----------------------------------------------------------------------------
interface ucb1_in_if #(
  parameter int COUNT_BITS = 24
) ();
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] win_count;
  logic [COUNT_BITS-1:0] visit_count;
  logic [COUNT_BITS-1:0] parent_visits;

  modport source (output valid, win_count, visit_count, parent_visits, input ready);
  modport sink (input valid, win_count, visit_count, parent_visits, output ready);
endinterface

interface ucb1_out_if ();
  logic                          valid;
  logic                          ready;
  logic [ucb1_pkg::RANK_W-1:0]   rank_value;
  logic                          unvisited;
  logic                          saturated;

  modport source (output valid, rank_value, unvisited, saturated, input ready);
  modport sink (input valid, rank_value, unvisited, saturated, output ready);
endinterface

/* rtl/ucb1_log2.sv */
// ----------------------------------------------------------------------------
// UCB1 log2 pipeline
// Leading-one stage, then one mantissa squaring per stage for each fraction
// bit of log2 in Q.16.
// ----------------------------------------------------------------------------
module ucb1_log2 #(
  parameter int XW  = 24,
  parameter int SBW = 48
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic [XW-1:0]                      x_i,
  input  logic [SBW-1:0]                     sb_i,
  output logic                               valid_o,
  output logic [$clog2(XW)+ucb1_pkg::FRAC_W-1:0] l2_o,
  output logic [SBW-1:0]                     sb_o
);

  localparam int EW = $clog2(XW);
  localparam int FW = ucb1_pkg::FRAC_W;
  localparam int MW = ucb1_pkg::MANT_W;

  logic          v_q  [FW+1];
  logic [MW-1:0] m_q  [FW+1];
  logic [EW-1:0] e_q  [FW+1];
  logic [FW-1:0] f_q  [FW+1];
  logic [SBW-1:0] sb_q [FW+1];

  logic [XW-1:0]      xs;
  logic [EW-1:0]      e_w;
  logic [XW+MW-2:0]   shifted;

  always_comb begin
    xs = (x_i == '0) ? XW'(1) : x_i;
    e_w = '0;
    for (int i = 0; i < XW; i++) begin
      if (xs[i]) begin
        e_w = EW'(i);
      end
    end
    shifted = {xs, {(MW-1){1'b0}}} >> e_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0]  <= shifted[MW-1:0];
      e_q[0]  <= e_w;
      f_q[0]  <= '0;
      sb_q[0] <= sb_i;
    end
  end

  for (genvar k = 1; k <= FW; k++) begin : g_sq
    logic [2*MW-1:0] sq;
    logic [MW:0]     m2;
    logic [FW-1:0]   f_next;

    always_comb begin
      sq = m_q[k-1] * m_q[k-1];
      m2 = sq[2*MW-1:MW-1];
      f_next = f_q[k-1];
      f_next[FW-k] = m2[MW];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[k]  <= m2[MW] ? m2[MW:1] : m2[MW-1:0];
        e_q[k]  <= e_q[k-1];
        f_q[k]  <= f_next;
        sb_q[k] <= sb_q[k-1];
      end
    end
  end

  assign valid_o = v_q[FW];
  assign l2_o    = {e_q[FW], f_q[FW]};
  assign sb_o    = sb_q[FW];

endmodule

/* rtl/ucb1_div.sv */
// ----------------------------------------------------------------------------
// UCB1 pipelined divider
// Restoring division, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module ucb1_div #(
  parameter int NW  = 40,
  parameter int DW  = 24,
  parameter int SBW = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [NW-1:0]  num_i,
  input  logic [DW-1:0]  den_i,
  input  logic [SBW-1:0] sb_i,
  output logic           valid_o,
  output logic [NW-1:0]  quot_o,
  output logic [SBW-1:0] sb_o
);

  logic           v_q   [NW];
  logic [DW-1:0]  rem_q [NW];
  logic [NW-1:0]  nq_q  [NW];
  logic [DW-1:0]  d_q   [NW];
  logic [SBW-1:0] sb_q  [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic           v_in;
    logic [DW-1:0]  rem_in;
    logic [NW-1:0]  nq_in;
    logic [DW-1:0]  d_in;
    logic [SBW-1:0] sb_in;
    logic [DW:0]    t;
    logic [DW:0]    diff;
    logic           ge;

    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign rem_in = '0;
      assign nq_in  = num_i;
      assign d_in   = den_i;
      assign sb_in  = sb_i;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign rem_in = rem_q[k-1];
      assign nq_in  = nq_q[k-1];
      assign d_in   = d_q[k-1];
      assign sb_in  = sb_q[k-1];
    end

    always_comb begin
      t    = {rem_in, nq_in[NW-1]};
      diff = t - {1'b0, d_in};
      ge   = (t >= {1'b0, d_in});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[DW-1:0] : t[DW-1:0];
        nq_q[k]  <= {nq_in[NW-2:0], ge};
        d_q[k]   <= d_in;
        sb_q[k]  <= sb_in;
      end
    end
  end

  assign valid_o = v_q[NW-1];
  assign quot_o  = nq_q[NW-1];
  assign sb_o    = sb_q[NW-1];

endmodule

/* rtl/ucb1_sqrt.sv */
// ----------------------------------------------------------------------------
// UCB1 pipelined square root
// Digit-by-digit integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module ucb1_sqrt #(
  parameter int VW  = 37,
  parameter int SBW = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [VW-1:0]        v_i,
  input  logic [SBW-1:0]       sb_i,
  output logic                 valid_o,
  output logic [(VW+1)/2-1:0]  root_o,
  output logic [SBW-1:0]       sb_o
);

  localparam int RW = (VW + 1) / 2;

  logic           v_q    [RW];
  logic [RW+1:0]  rem_q  [RW];
  logic [RW-1:0]  root_q [RW];
  logic [2*RW-1:0] vr_q  [RW];
  logic [SBW-1:0] sb_q   [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic            v_in;
    logic [RW+1:0]   rem_in;
    logic [RW-1:0]   root_in;
    logic [2*RW-1:0] vr_in;
    logic [SBW-1:0]  sb_in;
    logic [RW+1:0]   rem_sh;
    logic [RW+1:0]   trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign vr_in   = (2*RW)'(v_i);
      assign sb_in   = sb_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign vr_in   = vr_q[k-1];
      assign sb_in   = sb_q[k-1];
    end

    always_comb begin
      rem_sh = {rem_in[RW-1:0], vr_in[2*RW-1:2*RW-2]};
      trial  = {root_in, 2'b01};
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_q[k] <= {root_in[RW-2:0], ge};
        vr_q[k]   <= {vr_in[2*RW-3:0], 2'b00};
        sb_q[k]   <= sb_in;
      end
    end
  end

  assign valid_o = v_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign sb_o    = sb_q[RW-1];

endmodule

/* rtl/ucb1_node_rank_unit.sv */
// ----------------------------------------------------------------------------
// UCB1 node rank unit
// Pipeline: 17 log2 stages, 1 ln stage, COUNT_BITS+16 win rate divider stages,
// $clog2(COUNT_BITS)+32 ratio divider stages, half that (rounded up) square
// root stages, 1 scaling stage and 1 output stage.
// Throughput: one node per cycle; every stage holds while the output stalls.
// Reset clears all valid bits and loads the default configuration.
// ----------------------------------------------------------------------------
module ucb1_node_rank_unit #(
  parameter int COUNT_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ucb1_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ucb1_pkg::WEIGHT_W-1:0]        cfg_data_i,
  ucb1_in_if.sink                              in_i,
  ucb1_out_if.source                           out_o
);

  localparam int CB     = COUNT_BITS;
  localparam int FW     = ucb1_pkg::FRAC_W;
  localparam int L2W    = $clog2(CB) + FW;
  localparam int RATE_W = CB + FW;
  localparam int VW     = L2W + FW;
  localparam int RW     = (VW + 1) / 2;
  localparam int PW     = ucb1_pkg::WEIGHT_W + RW;
  localparam int EXPL_W = PW - ucb1_pkg::WEIGHT_SHIFT;
  localparam int SUMW   = ((RATE_W > EXPL_W) ? RATE_W : EXPL_W) + 1;

  logic [ucb1_pkg::WEIGHT_W-1:0] weight_q;
  logic                          unv_max_q;
  logic                          adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q  <= ucb1_pkg::WEIGHT_RESET;
      unv_max_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ucb1_pkg::CFG_IDX_WEIGHT:    weight_q  <= cfg_data_i;
        ucb1_pkg::CFG_IDX_UNVISITED: unv_max_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic           out_v_q;
  assign adv = !out_v_q || out_o.ready;
  assign in_i.ready = adv;

  logic           lg_v;
  logic [L2W-1:0] lg_l2;
  logic [2*CB-1:0] lg_sb;

  ucb1_log2 #(.XW(CB), .SBW(2*CB)) u_log2 (
    .clk_i, .rst_ni, .en_i(adv),
    .valid_i(in_i.valid),
    .x_i(in_i.parent_visits),
    .sb_i({in_i.win_count, in_i.visit_count}),
    .valid_o(lg_v), .l2_o(lg_l2), .sb_o(lg_sb)
  );

  logic [L2W+31:0] ln_prod;
  logic            ln_v_q;
  logic [L2W-1:0]  ln_q;
  logic [CB-1:0]   ln_win_q;
  logic [CB-1:0]   ln_vis_q;

  assign ln_prod = (L2W+32)'(lg_l2) * (L2W+32)'(ucb1_pkg::LN2_Q32);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ln_v_q <= 1'b0;
    end else if (adv) begin
      ln_v_q <= lg_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ln_q     <= ln_prod[L2W+31:32];
      ln_win_q <= lg_sb[2*CB-1:CB];
      ln_vis_q <= lg_sb[CB-1:0];
    end
  end

  logic              rd_v;
  logic [RATE_W-1:0] rd_rate;
  logic [L2W+CB-1:0] rd_sb;

  ucb1_div #(.NW(RATE_W), .DW(CB), .SBW(L2W+CB)) u_rate_div (
    .clk_i, .rst_ni, .en_i(adv),
    .valid_i(ln_v_q),
    .num_i({ln_win_q, {FW{1'b0}}}),
    .den_i(ln_vis_q),
    .sb_i({ln_q, ln_vis_q}),
    .valid_o(rd_v), .quot_o(rd_rate), .sb_o(rd_sb)
  );

  logic              qd_v;
  logic [VW-1:0]     qd_ratio;
  logic [RATE_W:0]   qd_sb;

  ucb1_div #(.NW(VW), .DW(CB), .SBW(RATE_W+1)) u_ratio_div (
    .clk_i, .rst_ni, .en_i(adv),
    .valid_i(rd_v),
    .num_i({rd_sb[L2W+CB-1:CB], {FW{1'b0}}}),
    .den_i(rd_sb[CB-1:0]),
    .sb_i({rd_rate, (rd_sb[CB-1:0] == '0)}),
    .valid_o(qd_v), .quot_o(qd_ratio), .sb_o(qd_sb)
  );

  logic            sq_v;
  logic [RW-1:0]   sq_root;
  logic [RATE_W:0] sq_sb;

  ucb1_sqrt #(.VW(VW), .SBW(RATE_W+1)) u_sqrt (
    .clk_i, .rst_ni, .en_i(adv),
    .valid_i(qd_v),
    .v_i(qd_ratio),
    .sb_i(qd_sb),
    .valid_o(sq_v), .root_o(sq_root), .sb_o(sq_sb)
  );

  logic [PW-1:0]     ex_prod;
  logic              ex_v_q;
  logic [EXPL_W-1:0] ex_q;
  logic [RATE_W-1:0] ex_rate_q;
  logic              ex_vz_q;

  assign ex_prod = PW'(weight_q) * PW'(sq_root);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_v_q <= 1'b0;
    end else if (adv) begin
      ex_v_q <= sq_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ex_q      <= ex_prod[PW-1:ucb1_pkg::WEIGHT_SHIFT];
      ex_rate_q <= sq_sb[RATE_W:1];
      ex_vz_q   <= sq_sb[0];
    end
  end

  logic [SUMW-1:0]             sum;
  logic                        sum_sat;
  logic [ucb1_pkg::RANK_W-1:0] rank_d;
  logic                        sat_d;
  logic [ucb1_pkg::RANK_W-1:0] rank_q;
  logic                        unv_q;
  logic                        sat_q;

  always_comb begin
    sum     = SUMW'(ex_rate_q) + SUMW'(ex_q);
    sum_sat = (sum > SUMW'(ucb1_pkg::RANK_MAX));
    if (ex_vz_q) begin
      rank_d = unv_max_q ? ucb1_pkg::RANK_MAX : '0;
      sat_d  = 1'b0;
    end else if (sum_sat) begin
      rank_d = ucb1_pkg::RANK_MAX;
      sat_d  = 1'b1;
    end else begin
      rank_d = sum[ucb1_pkg::RANK_W-1:0];
      sat_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= ex_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rank_q <= rank_d;
      unv_q  <= ex_vz_q;
      sat_q  <= sat_d;
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.rank_value = rank_q;
  assign out_o.unvisited  = unv_q;
  assign out_o.saturated  = sat_q;

endmodule

/* rtl/ucb1_nru_checker.sv */
// ----------------------------------------------------------------------------
// UCB1 node rank unit checker
// Port-level checks on the rank unit, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "ucb1_node_rank_unit_defines.svh"

module ucb1_nru_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [ucb1_pkg::RANK_W-1:0] rank_i,
  input logic                        unvisited_i,
  input logic                        saturated_i
);

  `UCB1_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(rank_i), "Stalled result changed.")
  `UCB1_ASSERT_NOW(a_unv_no_sat, out_valid_i && unvisited_i, !saturated_i, "Unvisited result flagged as saturated.")
  `UCB1_ASSERT_NOW(a_sat_max, out_valid_i && saturated_i, rank_i == ucb1_pkg::RANK_MAX, "Saturated rank is not the maximum.")
  `UCB1_ASSERT_NOW(a_in_ready, !out_valid_i || out_ready_i, in_ready_i, "Input refused while the output moves.")

endmodule

bind ucb1_node_rank_unit ucb1_nru_checker u_nru_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .rank_i      (out_o.rank_value),
  .unvisited_i (out_o.unvisited),
  .saturated_i (out_o.saturated)
);

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// UCB1 node rank unit testbench
// Drives node counts through the valid/ready input channel with random
// idling, predicts each rank in fixed point and checks every result transfer
// in order, across several exploration weights and both unvisited settings.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CB = 24;
  localparam int LATENCY = 116;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [ucb1_pkg::RANK_W-1:0] rank_value;
    logic                        unvisited;
    logic                        saturated;
  } rank_res_t;

  class rank_scoreboard;
    rank_res_t pending_ranks[$];
    logic [ucb1_pkg::WEIGHT_W-1:0] weight;
    logic unvisited_max;
    int errors;

    function new();
      weight = ucb1_pkg::WEIGHT_RESET;
      unvisited_max = 1'b0;
      errors = 0;
    endfunction

    function automatic logic [63:0] log2_fixed(logic [63:0] x);
      int e;
      logic [63:0] m;
      logic [63:0] frac;
      e = 0;
      frac = '0;
      while (e < 63 && (x >> (e + 1)) != 0) e++;
      if (e <= 30) m = x << (30 - e);
      else m = x >> (e - 30);
      for (int i = 15; i >= 0; i--) begin
        m = (m * m) >> 30;
        if (m >= (64'd2 << 30)) begin
          m = m >> 1;
          frac[i] = 1'b1;
        end
      end
      return (64'(e) << 16) | frac;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] b;
      res = '0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function void note_node(logic [CB-1:0] wins, logic [CB-1:0] visits,
                            logic [CB-1:0] parent);
      rank_res_t r;
      logic [63:0] rate, lnv, ratio, root, explore, rank, par, prod;
      r = '0;
      if (visits == 0) begin
        r.rank_value = unvisited_max ? ucb1_pkg::RANK_MAX : '0;
        r.unvisited = 1'b1;
      end else begin
        par = (parent == 0) ? 64'd1 : 64'(parent);
        rate = (64'(wins) << 16) / 64'(visits);
        prod = log2_fixed(par) * 64'(ucb1_pkg::LN2_Q32);
        lnv = prod >> 32;
        ratio = (lnv << 16) / 64'(visits);
        root = int_sqrt(ratio);
        explore = (64'(weight) * root) >> ucb1_pkg::WEIGHT_SHIFT;
        rank = rate + explore;
        if (rank > 64'(ucb1_pkg::RANK_MAX)) begin
          rank = 64'(ucb1_pkg::RANK_MAX);
          r.saturated = 1'b1;
        end
        r.rank_value = rank[ucb1_pkg::RANK_W-1:0];
      end
      pending_ranks.push_back(r);
    endfunction

    function void check_rank(rank_res_t got);
      rank_res_t exp_r;
      if (pending_ranks.size() == 0) begin
        $display("%0t: unexpected result rank=%h unv=%b sat=%b", $time,
                 got.rank_value, got.unvisited, got.saturated);
        errors++;
        return;
      end
      exp_r = pending_ranks.pop_front();
      if (got.rank_value !== exp_r.rank_value) begin
        $display("%0t: rank_value expected %h actual %h", $time,
                 exp_r.rank_value, got.rank_value);
        errors++;
      end
      if (got.unvisited !== exp_r.unvisited) begin
        $display("%0t: unvisited expected %b actual %b", $time,
                 exp_r.unvisited, got.unvisited);
        errors++;
      end
      if (got.saturated !== exp_r.saturated) begin
        $display("%0t: saturated expected %b actual %b", $time,
                 exp_r.saturated, got.saturated);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [ucb1_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [ucb1_pkg::WEIGHT_W-1:0] cfg_data_i = '0;

  ucb1_in_if #(.COUNT_BITS(CB)) node_ch ();
  ucb1_out_if rank_ch ();

  ucb1_node_rank_unit #(.COUNT_BITS(CB)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_i(node_ch.sink), .out_o(rank_ch.source)
  );

  always #5 clk_i = ~clk_i;

  rank_scoreboard ranks = new();
  bit quiet_phase = 1'b0;
  bit long_hold = 1'b0;
  int idle_cycles = 0;

  initial begin
    node_ch.valid = 1'b0;
    node_ch.win_count = '0;
    node_ch.visit_count = '0;
    node_ch.parent_visits = '0;
    rank_ch.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((node_ch.valid && node_ch.ready) || (rank_ch.valid && rank_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && node_ch.valid && node_ch.ready) begin
      ranks.note_node(node_ch.win_count, node_ch.visit_count, node_ch.parent_visits);
    end
    if (rst_ni && rank_ch.valid && rank_ch.ready) begin
      ranks.check_rank({rank_ch.rank_value, rank_ch.unvisited, rank_ch.saturated});
    end
  end

  initial begin
    int n;
    @(posedge clk_i);
    while (1) begin
      if (long_hold) begin
        rank_ch.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 18);
        rank_ch.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else begin
        n = $urandom_range(1, 30);
        rank_ch.ready <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  task automatic send_node(logic [CB-1:0] w, logic [CB-1:0] v, logic [CB-1:0] p);
    int n;
    if (!quiet_phase && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 18);
      node_ch.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    node_ch.valid <= 1'b1;
    node_ch.win_count <= w;
    node_ch.visit_count <= v;
    node_ch.parent_visits <= p;
    do @(posedge clk_i); while (!node_ch.ready);
  endtask

  task automatic drain();
    node_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (ranks.pending_ranks.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [ucb1_pkg::CFG_IDX_W-1:0] idx,
                           logic [ucb1_pkg::WEIGHT_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == ucb1_pkg::CFG_IDX_WEIGHT) ranks.weight = val;
    else if (idx == ucb1_pkg::CFG_IDX_UNVISITED) ranks.unvisited_max = val[0];
    @(posedge clk_i);
  endtask

  function automatic logic [CB-1:0] rand_count();
    case ($urandom_range(0, 4))
      0: return CB'($urandom_range(0, 15));
      1: return CB'($urandom_range(0, 1000));
      2: return '1 - CB'($urandom_range(0, 15));
      default: return CB'($urandom);
    endcase
  endfunction

  task automatic random_nodes(int count);
    logic [CB-1:0] w, v, p;
    for (int i = 0; i < count; i++) begin
      v = rand_count();
      p = rand_count();
      if ($urandom_range(0, 3) == 0) w = rand_count();
      else w = (v == 0) ? '0 : CB'($urandom_range(0, v));
      send_node(w, v, p);
    end
  endtask

  initial begin
    logic [ucb1_pkg::WEIGHT_W-1:0] weights[4];
    weights = '{16'd0, 16'hFFFF, 16'd4096, 16'd0};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_node(24'd0, 24'd0, 24'd1);
    send_node(24'hFFFFFF, 24'd0, 24'hFFFFFF);
    send_node(24'd0, 24'd1, 24'd1);
    send_node(24'd5, 24'd10, 24'd0);
    send_node(24'hFFFFFF, 24'd1, 24'hFFFFFF);
    send_node(24'd0, 24'hFFFFFF, 24'hFFFFFF);
    send_node(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_node(24'd20, 24'd10, 24'd100);
    send_node(24'd3, 24'd100, 24'd7);
    send_node(24'd1, 24'd1, 24'd2);
    send_node(24'd1, 24'd2, 24'hFFFFFF);
    send_node(24'h800000, 24'h000001, 24'h800000);
    send_node(24'h555555, 24'hAAAAAA, 24'h555555);
    send_node(24'hAAAAAA, 24'h555555, 24'hAAAAAA);
    random_nodes(250);
    drain();

    write_reg(ucb1_pkg::CFG_IDX_UNVISITED, 16'd1);
    weights[3] = ucb1_pkg::WEIGHT_W'($urandom);
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(ucb1_pkg::CFG_IDX_WEIGHT, weights[ph]);
      send_node(24'd0, 24'd0, 24'd5);
      send_node(24'd7, 24'd3, 24'hFFFFFF);
      if (ph == 1) long_hold = 1'b1;
      random_nodes(300);
      drain();
      if (ph == 1) write_reg(ucb1_pkg::CFG_IDX_UNVISITED, 16'd0);
    end

    write_reg(ucb1_pkg::CFG_IDX_WEIGHT, ucb1_pkg::WEIGHT_RESET);
    write_reg(ucb1_pkg::CFG_IDX_UNVISITED, 16'd1);
    quiet_phase = 1'b1;
    random_nodes(300);
    drain();

    if (ranks.errors == 0 && ranks.pending_ranks.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
